@@ sv/efp_pkg.sv @@
// ----------------------------------------------------------------------------
// efp_pkg - shared definitions for the effect pool fader
// pool geometry, effect type codes, opcodes, sequencer states and records
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int POOL_SIZE = 64;
  localparam int SLOT_W    = $clog2(POOL_SIZE);
  localparam int LINK_W    = $clog2(POOL_SIZE + 1);
  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(POOL_SIZE);

  localparam int MAX_RES = 64;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  localparam int OUT_SLOT_W = 6;
  localparam int FRAC_W     = 17;
  localparam int DIV_W      = 16;
  localparam logic [FRAC_W-1:0] ONE_Q16     = 17'h10000;
  localparam logic [16:0]       SCALE_ONE   = 17'd256;
  localparam logic [16:0]       SCALE_FLOOR = 17'd26;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  localparam logic [2:0] EFF_NONE         = 3'd0;
  localparam logic [2:0] EFF_RGB          = 3'd1;
  localparam logic [2:0] EFF_GROW_RGB     = 3'd2;
  localparam logic [2:0] EFF_SHRINK_RGB   = 3'd3;
  localparam logic [2:0] EFF_ALPHA        = 3'd4;
  localparam logic [2:0] EFF_GROW_ALPHA   = 3'd5;
  localparam logic [2:0] EFF_SHRINK_ALPHA = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_POP,
    ST_DETACH,
    ST_A_LINK,
    ST_A_HOOK,
    ST_A_OUT,
    ST_F_HEAD,
    ST_F_CHK,
    ST_F_AGE,
    ST_F_DIV,
    ST_F_MUL,
    ST_F_EMIT,
    ST_F_FREE,
    ST_F_XOUT,
    ST_F_NEXT,
    ST_F_END
  } state_e;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] start;
    logic [15:0] span;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] scale;
    logic [15:0] glow;
  } entry_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic                  entry_valid;
    logic                  evicted;
    logic                  expired;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic [16:0]           scale;
    logic [FRAC_W-1:0]     back;
    logic [15:0]           light;
    logic                  last;
  } res_t;

  function automatic logic is_slot(input logic [LINK_W-1:0] lk);
    return lk < NONE_LINK;
  endfunction

  function automatic logic [OUT_SLOT_W-1:0] slot_field(input logic [LINK_W-1:0] lk);
    logic [LINK_W+OUT_SLOT_W-1:0] wide;
    wide = (LINK_W+OUT_SLOT_W)'(lk);
    return wide[OUT_SLOT_W-1:0];
  endfunction

endpackage

@@ sv/efp_if.sv @@
// ----------------------------------------------------------------------------
// efp_if - input and output channels of the effect pool fader
// valid/ready handshake with the item or result fields as payload
// ----------------------------------------------------------------------------
interface efp_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] now_time;
  logic [2:0]  effect_type;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [7:0]  alpha_in;
  logic [15:0] lifetime;
  logic [15:0] base_scale;
  logic [15:0] light_level;

  modport source (output valid, opcode, now_time, effect_type, red_in, green_in, blue_in,
                  alpha_in, lifetime, base_scale, light_level, input ready);
  modport sink (input valid, opcode, now_time, effect_type, red_in, green_in, blue_in,
                alpha_in, lifetime, base_scale, light_level, output ready);
endinterface

interface efp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  slot;
  logic        entry_valid;
  logic        evicted;
  logic        expired;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [7:0]  alpha_out;
  logic [16:0] scale_out;
  logic [16:0] back_fraction;
  logic [15:0] light_out;
  logic        last;

  modport source (output valid, slot, entry_valid, evicted, expired, red_out, green_out,
                  blue_out, alpha_out, scale_out, back_fraction, light_out, last,
                  input ready);
  modport sink (input valid, slot, entry_valid, evicted, expired, red_out, green_out,
                blue_out, alpha_out, scale_out, back_fraction, light_out, last,
                output ready);
endinterface

@@ sv/efp_div.sv @@
// ----------------------------------------------------------------------------
// efp_div - radix-2 restoring divider
// computes floor(num * 2^16 / den) for num < den, one quotient bit per cycle
// ----------------------------------------------------------------------------
module efp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [efp_pkg::DIV_W-1:0]  num_i,
  input  logic [efp_pkg::DIV_W-1:0]  den_i,
  output logic                       done_o,
  output logic [efp_pkg::DIV_W-1:0]  quot_o
);

  localparam int CW = $clog2(efp_pkg::DIV_W + 1);

  logic [CW-1:0]             cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [efp_pkg::DIV_W:0]   rem_q;
  logic [efp_pkg::DIV_W-1:0] quot_q;
  logic [efp_pkg::DIV_W-1:0] den_q;

  logic [efp_pkg::DIV_W:0]   shifted;
  logic                      fits;

  assign shifted = {rem_q[efp_pkg::DIV_W-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CW'(efp_pkg::DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? (shifted - {1'b0, den_q}) : shifted;
      quot_q <= {quot_q[efp_pkg::DIV_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ sv/efp_links.sv @@
// ----------------------------------------------------------------------------
// efp_links - newer and older link memories of the pool
// one read address for both, one write port each, older links reset to i+1
// ----------------------------------------------------------------------------
module efp_links (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [efp_pkg::SLOT_W-1:0]  rd_addr_i,
  input  efp_pkg::link_wr_t           older_wr_i,
  input  efp_pkg::link_wr_t           newer_wr_i,
  output logic [efp_pkg::LINK_W-1:0]  rd_older_o,
  output logic [efp_pkg::LINK_W-1:0]  rd_newer_o
);

  logic [efp_pkg::LINK_W-1:0] older_mem [efp_pkg::POOL_SIZE];
  logic [efp_pkg::LINK_W-1:0] newer_mem [efp_pkg::POOL_SIZE];
  logic [efp_pkg::POOL_SIZE-1:0] older_vld_q;

  logic [efp_pkg::LINK_W-1:0] older_raw_q;
  logic [efp_pkg::LINK_W-1:0] newer_raw_q;
  logic                       rd_vld_q;
  logic [efp_pkg::SLOT_W-1:0] rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (older_wr_i.we) begin
      older_mem[older_wr_i.addr] <= older_wr_i.data;
    end
    if (newer_wr_i.we) begin
      newer_mem[newer_wr_i.addr] <= newer_wr_i.data;
    end
    if (rd_en_i) begin
      older_raw_q <= older_mem[rd_addr_i];
      newer_raw_q <= newer_mem[rd_addr_i];
    end
  end

  // unwritten older links read as the reset chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_vld_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_addr_q   <= '0;
    end else begin
      if (older_wr_i.we) begin
        older_vld_q[older_wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= older_vld_q[rd_addr_i];
        rd_addr_q <= rd_addr_i;
      end
    end
  end

  assign rd_older_o = rd_vld_q ? older_raw_q
                               : efp_pkg::LINK_W'(rd_addr_q) + efp_pkg::LINK_W'(1);
  assign rd_newer_o = newer_raw_q;

endmodule

@@ sv/effect_pool_fader_top.sv @@
// ----------------------------------------------------------------------------
// effect_pool_fader_top - pool of timed visual effects with per-frame fading
// allocate pops a free slot or evicts the oldest and links it as newest
// a frame fades each live entry with the 16-step divider, skipped when the
// fraction clamps, and 6 passes of the shared multiplier, and frees each expired
// entry; output stalls add waits; in is held off until the transaction is done
// reset clears the lists (all slots free, no active entry) at once, no sweep
// ----------------------------------------------------------------------------
module effect_pool_fader_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  efp_in_if.sink     in_i,
  efp_out_if.source  out_o
);

  localparam logic [2:0] MS_LIGHT = 3'd4;
  localparam logic [2:0] MS_SCALE = 3'd5;
  localparam int         MS_N     = 6;

  // sequencer and list heads
  efp_pkg::state_e state_q, state_d;
  logic [efp_pkg::LINK_W-1:0] free_head_q, free_head_d;
  logic [efp_pkg::LINK_W-1:0] newest_q, newest_d;
  logic [efp_pkg::LINK_W-1:0] oldest_q, oldest_d;
  logic [efp_pkg::LINK_W-1:0] cur_q, cur_d;
  logic [efp_pkg::LINK_W-1:0] steps_q, steps_d;
  logic [efp_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       ev_q, ev_d;
  logic [2:0]                 mstep_q, mstep_d;
  logic                       pend_v_q, pend_v_d;
  logic                       out_v_q, out_v_d;

  // captured item
  logic        op_q;
  logic [31:0] now_q;
  efp_pkg::entry_t new_q;

  // entry memory and read register
  efp_pkg::entry_t ent_mem [efp_pkg::POOL_SIZE];
  efp_pkg::entry_t ent_q;

  // fade datapath
  logic [31:0]                 age_q;
  logic [efp_pkg::FRAC_W-1:0]  frac_q;
  logic [efp_pkg::FRAC_W-1:0]  back_q;
  logic [16:0]                 mres_q [MS_N];
  efp_pkg::res_t pend_q, out_q;

  // strobes from the sequencer
  logic                       in_acc;
  logic                       rd_en;
  logic [efp_pkg::SLOT_W-1:0] rd_addr;
  efp_pkg::link_wr_t          owr, nwr;
  logic                       ent_we;
  logic                       div_start;
  logic                       out_ld, pend_ld;
  efp_pkg::res_t              out_nx, pend_nx;

  logic [efp_pkg::LINK_W-1:0] rd_older, rd_newer;
  logic                       div_done;
  logic [efp_pkg::DIV_W-1:0]  quot;

  logic        out_free;
  logic        room;
  logic        stall;
  logic        ex_hit;
  logic        clamp;
  logic        grow;
  logic [32:0] prod;
  logic [efp_pkg::FRAC_W-1:0] mul_a;
  logic [15:0]                mul_b;
  efp_pkg::res_t res_live, res_exp, res_empty;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_v_q || out_o.ready;
  assign room     = count_q < efp_pkg::CNT_W'(efp_pkg::MAX_RES);
  // a new frame result displaces the pending one into the output register
  assign stall    = room && pend_v_q && !out_free;

  // expiry: now later than start plus lifetime, with 32-bit wrap
  assign ex_hit = now_q > (ent_q.start + {16'b0, ent_q.span});
  assign clamp  = (ent_q.span == 16'd0) || (age_q >= {16'b0, ent_q.span});
  assign grow   = (ent_q.kind == efp_pkg::EFF_GROW_RGB) ||
                  (ent_q.kind == efp_pkg::EFF_GROW_ALPHA);

  efp_links u_links (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .older_wr_i (owr),
    .newer_wr_i (nwr),
    .rd_older_o (rd_older),
    .rd_newer_o (rd_newer)
  );

  efp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (age_q[efp_pkg::DIV_W-1:0]),
    .den_i   (ent_q.span),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // shared multiplier: three colour channels, alpha, light, then scale
  always_comb begin
    mul_a = (mstep_q == MS_SCALE && grow) ? frac_q : back_q;
    case (mstep_q)
      3'd0:     mul_b = {8'b0, ent_q.red};
      3'd1:     mul_b = {8'b0, ent_q.green};
      3'd2:     mul_b = {8'b0, ent_q.blue};
      3'd3:     mul_b = {8'b0, ent_q.alpha};
      MS_LIGHT: mul_b = ent_q.glow;
      default:  mul_b = ent_q.scale;
    endcase
  end
  assign prod = 33'(mul_a) * 33'(mul_b);

  // result records
  always_comb begin
    res_live             = '0;
    res_live.slot        = efp_pkg::slot_field(cur_q);
    res_live.entry_valid = 1'b1;
    res_live.back        = back_q;
    res_live.light       = mres_q[MS_LIGHT][15:0];
    case (ent_q.kind) inside
      efp_pkg::EFF_RGB, efp_pkg::EFF_GROW_RGB, efp_pkg::EFF_SHRINK_RGB: begin
        res_live.red   = mres_q[0][7:0];
        res_live.green = mres_q[1][7:0];
        res_live.blue  = mres_q[2][7:0];
        res_live.alpha = ent_q.alpha;
      end
      efp_pkg::EFF_ALPHA, efp_pkg::EFF_GROW_ALPHA, efp_pkg::EFF_SHRINK_ALPHA: begin
        res_live.red   = ent_q.red;
        res_live.green = ent_q.green;
        res_live.blue  = ent_q.blue;
        res_live.alpha = mres_q[3][7:0];
      end
      default: begin
        res_live.red   = 8'd0;
        res_live.green = 8'd0;
        res_live.blue  = 8'd0;
        res_live.alpha = 8'd0;
      end
    endcase
    case (ent_q.kind) inside
      efp_pkg::EFF_GROW_RGB, efp_pkg::EFF_GROW_ALPHA:
        res_live.scale = efp_pkg::SCALE_ONE + mres_q[MS_SCALE];
      efp_pkg::EFF_SHRINK_RGB, efp_pkg::EFF_SHRINK_ALPHA:
        res_live.scale = efp_pkg::SCALE_FLOOR + mres_q[MS_SCALE];
      default:
        res_live.scale = {1'b0, ent_q.scale};
    endcase

    res_exp             = '0;
    res_exp.slot        = efp_pkg::slot_field(cur_q);
    res_exp.entry_valid = 1'b1;
    res_exp.expired     = 1'b1;

    res_empty      = '0;
    res_empty.last = 1'b1;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    newest_d    = newest_q;
    oldest_d    = oldest_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    count_d     = count_q;
    ev_d        = ev_q;
    mstep_d     = mstep_q;
    pend_v_d    = pend_v_q;
    out_v_d     = out_v_q && !out_o.ready;
    rd_en       = 1'b0;
    rd_addr     = cur_q[efp_pkg::SLOT_W-1:0];
    owr         = '0;
    nwr         = '0;
    ent_we      = 1'b0;
    div_start   = 1'b0;
    out_ld      = 1'b0;
    out_nx      = '0;
    pend_ld     = 1'b0;
    pend_nx     = '0;

    unique case (state_q)
      efp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == efp_pkg::OP_ALLOC) begin
            state_d = efp_pkg::ST_A_RD;
          end else begin
            cur_d    = newest_q;
            steps_d  = '0;
            count_d  = '0;
            pend_v_d = 1'b0;
            state_d  = efp_pkg::ST_F_HEAD;
          end
        end
      end
      // allocation: pop the free list, else evict the oldest entry
      efp_pkg::ST_A_RD: begin
        ev_d = 1'b0;
        if (efp_pkg::is_slot(free_head_q)) begin
          rd_en   = 1'b1;
          rd_addr = free_head_q[efp_pkg::SLOT_W-1:0];
          cur_d   = free_head_q;
          state_d = efp_pkg::ST_A_POP;
        end else begin
          ev_d = 1'b1;
          if (efp_pkg::is_slot(oldest_q)) begin
            rd_en   = 1'b1;
            rd_addr = oldest_q[efp_pkg::SLOT_W-1:0];
            cur_d   = oldest_q;
            state_d = efp_pkg::ST_DETACH;
          end else begin
            cur_d   = '0;
            state_d = efp_pkg::ST_A_LINK;
          end
        end
      end
      efp_pkg::ST_A_POP: begin
        free_head_d = rd_older;
        state_d     = efp_pkg::ST_A_LINK;
      end
      // unlink cur from the active list using its fetched links
      efp_pkg::ST_DETACH: begin
        if (efp_pkg::is_slot(rd_newer)) begin
          owr = '{we: 1'b1, addr: rd_newer[efp_pkg::SLOT_W-1:0], data: rd_older};
        end else begin
          newest_d = rd_older;
        end
        if (efp_pkg::is_slot(rd_older)) begin
          nwr = '{we: 1'b1, addr: rd_older[efp_pkg::SLOT_W-1:0], data: rd_newer};
        end else begin
          oldest_d = rd_newer;
        end
        state_d = (op_q == efp_pkg::OP_ALLOC) ? efp_pkg::ST_A_LINK : efp_pkg::ST_F_FREE;
      end
      efp_pkg::ST_A_LINK: begin
        ent_we  = 1'b1;
        nwr     = '{we: 1'b1, addr: cur_q[efp_pkg::SLOT_W-1:0], data: efp_pkg::NONE_LINK};
        owr     = '{we: 1'b1, addr: cur_q[efp_pkg::SLOT_W-1:0], data: newest_q};
        state_d = efp_pkg::ST_A_HOOK;
      end
      efp_pkg::ST_A_HOOK: begin
        if (efp_pkg::is_slot(newest_q)) begin
          nwr = '{we: 1'b1, addr: newest_q[efp_pkg::SLOT_W-1:0], data: cur_q};
        end else begin
          oldest_d = cur_q;
        end
        newest_d = cur_q;
        state_d  = efp_pkg::ST_A_OUT;
      end
      efp_pkg::ST_A_OUT: begin
        if (out_free) begin
          out_ld             = 1'b1;
          out_nx.slot        = efp_pkg::slot_field(cur_q);
          out_nx.entry_valid = 1'b1;
          out_nx.evicted     = ev_q;
          out_nx.last        = 1'b1;
          state_d            = efp_pkg::ST_IDLE;
        end
      end
      // frame walk, newest to oldest
      efp_pkg::ST_F_HEAD: begin
        if (!efp_pkg::is_slot(cur_q) || steps_q == efp_pkg::LINK_W'(efp_pkg::POOL_SIZE)) begin
          state_d = efp_pkg::ST_F_END;
        end else begin
          rd_en   = 1'b1;
          state_d = efp_pkg::ST_F_CHK;
        end
      end
      efp_pkg::ST_F_CHK: begin
        state_d = ex_hit ? efp_pkg::ST_DETACH : efp_pkg::ST_F_AGE;
      end
      efp_pkg::ST_F_AGE: begin
        mstep_d = '0;
        if (clamp) begin
          state_d = efp_pkg::ST_F_MUL;
        end else begin
          div_start = 1'b1;
          state_d   = efp_pkg::ST_F_DIV;
        end
      end
      efp_pkg::ST_F_DIV: begin
        mstep_d = '0;
        if (div_done) begin
          state_d = efp_pkg::ST_F_MUL;
        end
      end
      efp_pkg::ST_F_MUL: begin
        mstep_d = mstep_q + 3'd1;
        if (mstep_q == MS_SCALE) begin
          state_d = efp_pkg::ST_F_EMIT;
        end
      end
      efp_pkg::ST_F_EMIT, efp_pkg::ST_F_XOUT: begin
        if (!stall) begin
          if (room) begin
            pend_ld  = 1'b1;
            pend_nx  = (state_q == efp_pkg::ST_F_EMIT) ? res_live : res_exp;
            out_ld   = pend_v_q;
            out_nx   = pend_q;
            pend_v_d = 1'b1;
            count_d  = count_q + efp_pkg::CNT_W'(1);
          end
          state_d = efp_pkg::ST_F_NEXT;
        end
      end
      efp_pkg::ST_F_FREE: begin
        owr         = '{we: 1'b1, addr: cur_q[efp_pkg::SLOT_W-1:0], data: free_head_q};
        free_head_d = cur_q;
        state_d     = efp_pkg::ST_F_XOUT;
      end
      efp_pkg::ST_F_NEXT: begin
        cur_d   = rd_older;
        steps_d = steps_q + efp_pkg::LINK_W'(1);
        state_d = efp_pkg::ST_F_HEAD;
      end
      efp_pkg::ST_F_END: begin
        if (out_free) begin
          out_ld      = 1'b1;
          out_nx      = pend_v_q ? pend_q : res_empty;
          out_nx.last = 1'b1;
          pend_v_d    = 1'b0;
          state_d     = efp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = efp_pkg::ST_IDLE;
      end
    endcase

    if (out_ld) begin
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efp_pkg::ST_IDLE;
      free_head_q <= '0;
      newest_q    <= efp_pkg::NONE_LINK;
      oldest_q    <= efp_pkg::NONE_LINK;
      cur_q       <= efp_pkg::NONE_LINK;
      steps_q     <= '0;
      count_q     <= '0;
      ev_q        <= 1'b0;
      mstep_q     <= '0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      newest_q    <= newest_d;
      oldest_q    <= oldest_d;
      cur_q       <= cur_d;
      steps_q     <= steps_d;
      count_q     <= count_d;
      ev_q        <= ev_d;
      mstep_q     <= mstep_d;
      pend_v_q    <= pend_v_d;
      out_v_q     <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q        <= in_i.opcode;
      now_q       <= in_i.now_time;
      new_q.kind  <= in_i.effect_type;
      new_q.start <= in_i.now_time;
      new_q.span  <= in_i.lifetime;
      new_q.red   <= in_i.red_in;
      new_q.green <= in_i.green_in;
      new_q.blue  <= in_i.blue_in;
      new_q.alpha <= in_i.alpha_in;
      new_q.scale <= in_i.base_scale;
      new_q.glow  <= in_i.light_level;
    end
    if (ent_we) begin
      ent_mem[cur_q[efp_pkg::SLOT_W-1:0]] <= new_q;
    end
    if (rd_en) begin
      ent_q <= ent_mem[rd_addr];
    end
    if (state_q == efp_pkg::ST_F_CHK) begin
      age_q <= now_q - ent_q.start;
    end
    if (state_q == efp_pkg::ST_F_AGE && clamp) begin
      frac_q <= efp_pkg::ONE_Q16;
      back_q <= '0;
    end
    if (state_q == efp_pkg::ST_F_DIV && div_done) begin
      frac_q <= {1'b0, quot};
      back_q <= efp_pkg::ONE_Q16 - {1'b0, quot};
    end
    if (state_q == efp_pkg::ST_F_MUL) begin
      mres_q[mstep_q] <= prod[32:16];
    end
    if (pend_ld) begin
      pend_q <= pend_nx;
    end
    if (out_ld) begin
      out_q <= out_nx;
    end
  end

  // ports
  assign in_i.ready          = (state_q == efp_pkg::ST_IDLE);
  assign out_o.valid         = out_v_q;
  assign out_o.slot          = out_q.slot;
  assign out_o.entry_valid   = out_q.entry_valid;
  assign out_o.evicted       = out_q.evicted;
  assign out_o.expired       = out_q.expired;
  assign out_o.red_out       = out_q.red;
  assign out_o.green_out     = out_q.green;
  assign out_o.blue_out      = out_q.blue;
  assign out_o.alpha_out     = out_q.alpha;
  assign out_o.scale_out     = out_q.scale;
  assign out_o.back_fraction = out_q.back;
  assign out_o.light_out     = out_q.light;
  assign out_o.last          = out_q.last;

  // active list ends are either both set or both empty
  a_ends_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    efp_pkg::is_slot(newest_q) == efp_pkg::is_slot(oldest_q))
    else $error("active list head and tail disagree");

  // divider finishes only while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == efp_pkg::ST_F_DIV)
    else $error("divider result with no waiting sequencer");

  // frame result count stays within the reported limit
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= efp_pkg::CNT_W'(efp_pkg::MAX_RES))
    else $error("frame result count overflow");

  // a result is never loaded over one still waiting to be taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |=> $stable(out_q))
    else $error("output transaction overwritten");

endmodule

@@ tb/tb_effect_pool_fader_top.sv @@
// ----------------------------------------------------------------------------
// tb_effect_pool_fader_top - self-checking bench for the effect pool fader
// drives allocate and frame transactions with random gaps, predicts the
// pool lists and faded results, and compares every result transaction
// ----------------------------------------------------------------------------
class fade_scoreboard;
  typedef struct packed {
    logic [5:0]  slot;
    logic        entry_valid;
    logic        evicted;
    logic        expired;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [16:0] scale;
    logic [16:0] back;
    logic [15:0] light;
    logic        last;
  } fade_res_t;

  // model copy of the pool
  logic [2:0]  kind_q [64];
  logic [31:0] start_q [64];
  logic [15:0] span_q [64];
  logic [7:0]  col_q [64][4];
  logic [15:0] scale_q [64];
  logic [15:0] glow_q [64];
  int          newer_q [64];
  int          older_q [64];
  int          free_top;
  int          newest;
  int          oldest;

  fade_res_t   pending_q[$];
  int          mismatches;

  function new();
    for (int i = 0; i < 64; i++) begin
      newer_q[i] = 64;
      older_q[i] = i + 1;
    end
    free_top = 0;
    newest = 64;
    oldest = 64;
    mismatches = 0;
  endfunction

  function void unlink(int s);
    int n;
    int o;
    n = newer_q[s];
    o = older_q[s];
    if (n < 64) older_q[n] = o; else newest = o;
    if (o < 64) newer_q[o] = n; else oldest = n;
  endfunction

  // predict results of one accepted input transaction
  function void note_item(logic op, logic [31:0] now_t, logic [2:0] kind,
                          logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                          logic [15:0] life, logic [15:0] base, logic [15:0] glow);
    fade_res_t res;
    int        s;
    int        nxt;
    int        cnt;
    logic [31:0] age;
    logic [31:0] frac;
    logic [31:0] back;
    logic [31:0] ch [4];
    logic [63:0] sc;
    if (op == efp_pkg::OP_ALLOC) begin
      res = '0;
      if (free_top < 64) begin
        s = free_top;
        free_top = older_q[s];
      end else begin
        s = oldest;
        unlink(s);
        res.evicted = 1'b1;
      end
      kind_q[s] = kind; start_q[s] = now_t; span_q[s] = life;
      col_q[s][0] = r; col_q[s][1] = g; col_q[s][2] = b; col_q[s][3] = a;
      scale_q[s] = base; glow_q[s] = glow;
      newer_q[s] = 64;
      older_q[s] = newest;
      if (newest < 64) newer_q[newest] = s; else oldest = s;
      newest = s;
      res.slot = s[5:0];
      res.entry_valid = 1'b1;
      res.last = 1'b1;
      pending_q.push_back(res);
      return;
    end
    s = newest;
    cnt = 0;
    while (s < 64) begin
      nxt = older_q[s];
      res = '0;
      res.slot = s[5:0];
      res.entry_valid = 1'b1;
      if (now_t > start_q[s] + {16'd0, span_q[s]}) begin
        unlink(s);
        older_q[s] = free_top;
        free_top = s;
        res.expired = 1'b1;
      end else begin
        age = now_t - start_q[s];
        if (span_q[s] == 0 || age >= span_q[s]) frac = 32'h10000;
        else frac = ({32'd0, age} << 16) / span_q[s];
        back = 32'h10000 - frac;
        for (int i = 0; i < 4; i++) ch[i] = col_q[s][i];
        case (kind_q[s])
          efp_pkg::EFF_RGB, efp_pkg::EFF_GROW_RGB, efp_pkg::EFF_SHRINK_RGB:
            for (int i = 0; i < 3; i++) ch[i] = (ch[i] * back) >> 16;
          efp_pkg::EFF_ALPHA, efp_pkg::EFF_GROW_ALPHA, efp_pkg::EFF_SHRINK_ALPHA:
            ch[3] = (ch[3] * back) >> 16;
          default:
            for (int i = 0; i < 4; i++) ch[i] = 0;
        endcase
        case (kind_q[s])
          efp_pkg::EFF_GROW_RGB, efp_pkg::EFF_GROW_ALPHA:
            sc = 256 + ((64'(frac) * scale_q[s]) >> 16);
          efp_pkg::EFF_SHRINK_RGB, efp_pkg::EFF_SHRINK_ALPHA:
            sc = 26 + ((64'(back) * scale_q[s]) >> 16);
          default: sc = scale_q[s];
        endcase
        res.red = ch[0][7:0]; res.green = ch[1][7:0];
        res.blue = ch[2][7:0]; res.alpha = ch[3][7:0];
        res.scale = sc[16:0];
        res.back = back[16:0];
        res.light = 16'((64'(glow_q[s]) * back) >> 16);
      end
      pending_q.push_back(res);
      cnt++;
      s = nxt;
    end
    if (cnt == 0) begin
      res = '0;
      pending_q.push_back(res);
    end
    pending_q[pending_q.size() - 1].last = 1'b1;
  endfunction

  function void check_result(fade_res_t got);
    fade_res_t want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result transaction %h", got);
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch slot %0d/%0d v %b/%b ev %b/%b ex %b/%b",
                 want.slot, got.slot, want.entry_valid, got.entry_valid,
                 want.evicted, got.evicted, want.expired, got.expired);
        $display("  rgba %h%h%h%h/%h%h%h%h scale %0d/%0d back %0d/%0d light %0d/%0d last %b/%b",
                 want.red, want.green, want.blue, want.alpha,
                 got.red, got.green, got.blue, got.alpha, want.scale, got.scale,
                 want.back, got.back, want.light, got.light, want.last, got.last);
      end
    end
  endfunction
endclass

module tb_effect_pool_fader_top;

  logic clk_i;
  logic rst_ni;
  int   cycle_cnt;
  int   hold_off;       // cycles left in the long receiver stall
  logic [31:0] clock_ms; // running time base for the stimulus

  efp_in_if  in_ch ();
  efp_out_if out_ch ();

  effect_pool_fader_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  fade_scoreboard fade_sb;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, generous over slowest run (64 live entries, long stalls)
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 20000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sample results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      fade_sb.check_result({out_ch.slot, out_ch.entry_valid, out_ch.evicted, out_ch.expired,
                            out_ch.red_out, out_ch.green_out, out_ch.blue_out,
                            out_ch.alpha_out, out_ch.scale_out, out_ch.back_fraction,
                            out_ch.light_out, out_ch.last});
    end
  end

  // receiver: random stalls, plus one long hold-off when requested
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    hold_off = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off = hold_off - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // present one transaction and wait until it is accepted
  task automatic send_item(logic op, logic [31:0] now_t, logic [2:0] kind,
                           logic [31:0] rgba, logic [15:0] life,
                           logic [15:0] base, logic [15:0] glow);
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.now_time    <= now_t;
    in_ch.effect_type <= kind;
    in_ch.red_in      <= rgba[7:0];
    in_ch.green_in    <= rgba[15:8];
    in_ch.blue_in     <= rgba[23:16];
    in_ch.alpha_in    <= rgba[31:24];
    in_ch.lifetime    <= life;
    in_ch.base_scale  <= base;
    in_ch.light_level <= glow;
    do @(posedge clk_i); while (!in_ch.ready);
    fade_sb.note_item(op, now_t, kind, rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24],
                      life, base, glow);
    @(negedge clk_i);
  endtask

  // random idle on the input side, mostly short
  task automatic input_gap();
    int gap;
    if ($urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 20) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_alloc(logic [2:0] kind, logic [15:0] life);
    send_item(efp_pkg::OP_ALLOC, clock_ms, kind, $urandom, life, 16'($urandom),
              16'($urandom));
  endtask

  task automatic send_frame(logic [31:0] now_t);
    send_item(efp_pkg::OP_FRAME, now_t, 3'($urandom), $urandom, 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  initial begin
    int tail;
    int life_pick;
    fade_sb = new();
    cycle_cnt = 0;
    clock_ms = 32'd1000;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = efp_pkg::OP_ALLOC;
    in_ch.now_time = '0;
    in_ch.effect_type = efp_pkg::EFF_NONE;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    in_ch.alpha_in = '0;
    in_ch.lifetime = '0;
    in_ch.base_scale = '0;
    in_ch.light_level = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty frame, every type, extreme fields
    send_frame(32'd0);
    send_item(efp_pkg::OP_ALLOC, 32'd1000, efp_pkg::EFF_NONE, 32'hFFFF_FFFF, 16'hFFFF,
              16'hFFFF, 16'hFFFF);
    send_item(efp_pkg::OP_ALLOC, 32'd1000, efp_pkg::EFF_RGB, 32'hFFFF_FFFF, 16'd0,
              16'd0, 16'd0);
    send_item(efp_pkg::OP_ALLOC, 32'd1000, efp_pkg::EFF_GROW_RGB, 32'h8040_20FF, 16'd100,
              16'hFFFF, 16'hFFFF);
    send_item(efp_pkg::OP_ALLOC, 32'd1000, efp_pkg::EFF_SHRINK_RGB, 32'h0000_0000, 16'd100,
              16'h0100, 16'h0001);
    send_item(efp_pkg::OP_ALLOC, 32'd1000, efp_pkg::EFF_ALPHA, 32'hFF00_00FF, 16'd1,
              16'h1234, 16'hFFFF);
    send_item(efp_pkg::OP_ALLOC, 32'd1000, efp_pkg::EFF_GROW_ALPHA, 32'hFFFF_FFFF, 16'd3000,
              16'hFFFF, 16'd7);
    send_item(efp_pkg::OP_ALLOC, 32'd1000, efp_pkg::EFF_SHRINK_ALPHA, 32'h7F7F_7F7F,
              16'd3000, 16'hFFFF, 16'd9);
    send_item(efp_pkg::OP_ALLOC, 32'd1000, 3'd7, 32'h1122_3344, 16'd50, 16'd300, 16'd500);
    // time before start wraps the age, zero lifetime clamps
    send_frame(32'd999);
    send_frame(32'd1000);
    send_frame(32'd1050);
    send_frame(32'd1101);
    // wrap of start plus lifetime
    send_item(efp_pkg::OP_ALLOC, 32'hFFFF_FFF0, efp_pkg::EFF_RGB, 32'hFFFF_FFFF, 16'hFFFF,
              16'd256, 16'hFFFF);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'd5);
    // everything expires
    send_frame(32'hFFFF_FFFF);
    clock_ms = 32'd2000;

    // random: mostly allocations with occasional frames, several full pool runs
    for (int n = 0; n < 500; n++) begin
      input_gap();
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 9) == 0) send_frame($urandom);
        else send_frame(clock_ms + $urandom_range(0, 400));
        clock_ms = clock_ms + $urandom_range(0, 60);
      end else begin
        life_pick = $urandom_range(0, 9);
        if (life_pick == 0) send_alloc(3'($urandom), 16'd0);
        else if (life_pick == 1) send_alloc(3'($urandom), 16'($urandom));
        else send_alloc(3'($urandom), 16'($urandom_range(1, 300)));
        clock_ms = clock_ms + $urandom_range(0, 5);
      end
      // long receiver stall while input keeps offering
      if (n == 250) hold_off = 2000;
    end
    in_ch.valid <= 1'b0;

    tail = 0;
    while (fade_sb.pending_q.size() != 0) @(posedge clk_i);
    while (tail < 200) begin
      @(posedge clk_i);
      tail++;
    end
    if (fade_sb.mismatches == 0 && fade_sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/efp_pkg.sv
sv/efp_if.sv
sv/efp_div.sv
sv/efp_links.sv
sv/effect_pool_fader_top.sv
tb/tb_effect_pool_fader_top.sv
